>>> src/sha_pkg.sv
package sha_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenPos     = 56;
  localparam int unsigned Rounds     = 64;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_e;

  typedef logic [31:0] word_t;

  localparam word_t InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(word_t x, int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

>>> src/sha256_stream_hasher.sv
// Streaming SHA-256: at most one message byte per input beat, eight digest words
// out after the beat marked last. A byte that does not complete a block is taken
// without a stall. A byte that completes a block starts the shared round unit,
// which runs one round per cycle and then a fold step, while in_stall_o is high.
// The last beat pads through the block register one byte a cycle (plus a second
// compression when the length does not fit), then shows the eight digest words,
// one per output beat. Message schedule words live in a 16-word sliding window
// of the block register, so no memory is used.
module sha256_stream_hasher (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sha_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sha_pkg::out_beat_t out_data_o
);

  sha_pkg::state_e state_q, state_d;
  logic [511:0] blk_q, blk_d;           // bytes shift in at the low end
  logic [5:0]   fill_q, fill_d;
  logic [63:0]  len_q, len_d;
  logic [5:0]   rnd_q, rnd_d;
  logic [2:0]   widx_q, widx_d;
  logic         fin_q, fin_d;           // padding in progress
  logic [63:0]  plen_q, plen_d;         // length captured at last beat
  logic         p80_q, p80_d;           // 0x80 marker still pending
  logic         lenok_q, lenok_d;       // current block carries the length
  logic         pad_done_q, pad_done_d; // block being compressed is the final one
  sha_pkg::word_t h_q [8], h_d [8];
  sha_pkg::word_t v_q [8], v_d [8];     // a..h

  logic         in_acc;
  logic [7:0]   pad_byte;
  logic [5:0]   lsel;
  sha_pkg::word_t w_cur, w_new, s0, s1, t1, t2;

  assign in_acc = in_valid_i && !in_stall_o;

  // schedule: window head is W[t]; new word W[t+16]
  always_comb begin
    w_cur = blk_q[511:480];
    s0 = sha_pkg::rotr(blk_q[479:448], 7) ^ sha_pkg::rotr(blk_q[479:448], 18)
       ^ (blk_q[479:448] >> 3);
    s1 = sha_pkg::rotr(blk_q[63:32], 17) ^ sha_pkg::rotr(blk_q[63:32], 19)
       ^ (blk_q[63:32] >> 10);
    w_new = w_cur + s0 + blk_q[223:192] + s1;
    t1 = v_q[7] + (sha_pkg::rotr(v_q[4], 6) ^ sha_pkg::rotr(v_q[4], 11)
       ^ sha_pkg::rotr(v_q[4], 25)) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
       + sha_pkg::RoundK[rnd_q] + w_cur;
    t2 = (sha_pkg::rotr(v_q[0], 2) ^ sha_pkg::rotr(v_q[0], 13)
       ^ sha_pkg::rotr(v_q[0], 22))
       + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  // padding byte for the current fill position; length goes big-endian
  assign lsel = {3'd7 - fill_q[2:0], 3'b000};

  always_comb begin
    if (p80_q) pad_byte = 8'h80;
    else if (lenok_q && fill_q >= 6'(sha_pkg::LenPos)) pad_byte = plen_q[lsel +: 8];
    else pad_byte = 8'h00;
  end

  // sequencer
  always_comb begin
    state_d = state_q; blk_d = blk_q; fill_d = fill_q; len_d = len_q;
    rnd_d = rnd_q; widx_d = widx_q; fin_d = fin_q; plen_d = plen_q;
    p80_d = p80_q; lenok_d = lenok_q; pad_done_d = pad_done_q;
    h_d = h_q; v_d = v_q;
    in_stall_o = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      sha_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_acc) begin
          if (in_data_i.has_byte) begin
            blk_d = {blk_q[503:0], in_data_i.data_byte};
            fill_d = fill_q + 6'd1;
            len_d = len_q + 64'd8;
          end
          if (in_data_i.is_last) begin
            fin_d = 1'b1; p80_d = 1'b1;
            plen_d = in_data_i.has_byte ? len_q + 64'd8 : len_q;
          end
          if (in_data_i.has_byte && fill_q == 6'd63) begin
            state_d = sha_pkg::ST_ROUND; rnd_d = '0; v_d = h_q;
          end else if (in_data_i.is_last) state_d = sha_pkg::ST_PAD;
        end
      end
      sha_pkg::ST_PAD: begin
        blk_d = {blk_q[503:0], pad_byte};
        fill_d = fill_q + 6'd1;
        p80_d = 1'b0;
        // marker before the length field: length fits in this block
        if (p80_q && fill_q < 6'(sha_pkg::LenPos)) lenok_d = 1'b1;
        if (fill_q == 6'd63) begin
          state_d = sha_pkg::ST_ROUND; rnd_d = '0; v_d = h_q;
          if (lenok_q) begin
            fin_d = 1'b0; lenok_d = 1'b0; pad_done_d = 1'b1;
          end else begin
            lenok_d = 1'b1;
          end
        end
      end
      sha_pkg::ST_ROUND: begin
        v_d[7] = v_q[6]; v_d[6] = v_q[5]; v_d[5] = v_q[4];
        v_d[4] = v_q[3] + t1;
        v_d[3] = v_q[2]; v_d[2] = v_q[1]; v_d[1] = v_q[0];
        v_d[0] = t1 + t2;
        blk_d = {blk_q[479:0], w_new};
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'(sha_pkg::Rounds - 1)) state_d = sha_pkg::ST_FOLD;
      end
      sha_pkg::ST_FOLD: begin
        for (int i = 0; i < 8; i++) h_d[i] = h_q[i] + v_q[i];
        pad_done_d = 1'b0;
        if (fin_q) state_d = sha_pkg::ST_PAD;
        else if (pad_done_q) state_d = sha_pkg::ST_EMIT;
        else state_d = sha_pkg::ST_IDLE;
      end
      sha_pkg::ST_EMIT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          widx_d = widx_q + 3'd1;
          if (widx_q == 3'd7) begin
            state_d = sha_pkg::ST_IDLE;
            for (int i = 0; i < 8; i++) h_d[i] = sha_pkg::InitHash[i];
            fill_d = '0; len_d = '0; widx_d = '0;
          end
        end
      end
      default: state_d = sha_pkg::ST_IDLE;
    endcase
  end

  assign out_data_o.digest_word = h_q[widx_q];
  assign out_data_o.word_index  = widx_q;
  assign out_data_o.last_word   = (widx_q == 3'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha_pkg::ST_IDLE;
      fill_q <= '0; len_q <= '0; rnd_q <= '0; widx_q <= '0;
      fin_q <= 1'b0; p80_q <= 1'b0; lenok_q <= 1'b0; pad_done_q <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::InitHash[i];
    end else begin
      state_q <= state_d;
      fill_q <= fill_d; len_q <= len_d; rnd_q <= rnd_d; widx_q <= widx_d;
      fin_q <= fin_d; p80_q <= p80_d; lenok_q <= lenok_d; pad_done_q <= pad_done_d;
      h_q <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d; plen_q <= plen_d; v_q <= v_d;
  end

`ifndef SYNTHESIS
  a_no_out_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken during digest output");
  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(widx_q))
    else $error("digest beat dropped");
  a_round_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sha_pkg::ST_ROUND |-> in_stall_o) else $error("busy not stalled");
  a_emit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fill_q == 6'd0) else $error("emit with partial block");
`endif

endmodule
